// ===== rtl/differential_drive_controller_defines.svh =====
// Assertion macros for the checker file.
`ifndef DIFFERENTIAL_DRIVE_CONTROLLER_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, reset masks the check
`define DDC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masks the check
`define DDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ddc_pkg.sv =====
package ddc_pkg;

    // Field widths
    localparam int ERR_W  = 17;
    localparam int SPD_W  = 8;
    localparam int STR_W  = 8;
    localparam int DUTY_W = 14;
    localparam int INT_W  = 15;

    // Default speed scale
    localparam int DEFAULT_MAX_SPEED = 100;

    // Duty and integrator limits
    localparam int POWER_MIN  = 400;
    localparam int POWER_MAX  = 12100;
    localparam int INT_MAX    = 11000;
    localparam int INT_MIN    = -500;
    localparam int DUTY_MIN   = POWER_MAX / 4;
    localparam int INNER_MIN  = POWER_MIN / 2;
    localparam int STEER_LIM  = 45;
    localparam int SERVO_GAIN = 125;
    localparam int SERVO_DIV  = 9;
    localparam int SERVO_BASE = 1250;

    // Result buffer depth: a drive item writes four beats
    localparam int RES_MAX = 4;
    localparam int CNT_W   = $clog2(RES_MAX + 1);

    // Request codes
    typedef enum logic [1:0] {
        REQ_PI    = 2'd0,
        REQ_DRIVE = 2'd1,
        REQ_STOP  = 2'd2
    } t_req;

    // PWM channel codes
    localparam logic [1:0] CH_LEFT  = 2'd0;
    localparam logic [1:0] CH_RIGHT = 2'd1;
    localparam logic [1:0] CH_SERVO = 2'd2;

    typedef struct packed {
        logic [1:0]              req_type;
        logic signed [ERR_W-1:0] error;
        logic signed [SPD_W-1:0] speed;
        logic signed [STR_W-1:0] steer;
    } t_item;

    typedef struct packed {
        logic [1:0]        channel;
        logic [DUTY_W-1:0] duty;
        logic              reverse;
        logic              last;
    } t_result;

    typedef struct packed {
        logic signed [INT_W-1:0] left_int;
        logic signed [INT_W-1:0] right_int;
        logic                    halted;
    } t_state;

    // Load request from the core into the result buffer
    typedef struct packed {
        logic             load;
        logic [CNT_W-1:0] cnt;
    } t_load;

endpackage

// ===== rtl/ddc_calc.sv =====
module ddc_calc import ddc_pkg::*; #(
    parameter int MAX_SPEED = DEFAULT_MAX_SPEED
) (
    input  t_item                     i_item,
    input  t_state                    i_state,
    output t_state                    o_state,
    output t_result [RES_MAX-1:0]     o_res,
    output logic [CNT_W-1:0]          o_cnt
);

    localparam int PW_N    = MAX_SPEED + 1;
    localparam int PW_IW   = $clog2(PW_N);
    localparam int SRV_N   = 2 * STEER_LIM + 1;
    localparam int SRV_IW  = $clog2(SRV_N);
    localparam int SUM_W   = ERR_W + 3;
    localparam int DUTY_XW = ERR_W + 6;

    // Power table: speed magnitude to wheel duty, floor at minimum power
    logic [DUTY_W-1:0] pw_lut [PW_N];
    for (genvar g = 0; g < PW_N; g++) begin : g_pw
        localparam int RAW = (g * POWER_MAX) / MAX_SPEED;
        localparam int PW  = (RAW < POWER_MIN) ? POWER_MIN : RAW;
        assign pw_lut[g] = DUTY_W'(PW);
    end

    // Servo table: offset (limit - steer) to servo duty
    logic [DUTY_W-1:0] srv_lut [SRV_N];
    for (genvar g = 0; g < SRV_N; g++) begin : g_srv
        localparam int SD = (g * SERVO_GAIN) / SERVO_DIV + SERVO_BASE;
        assign srv_lut[g] = DUTY_W'(SD);
    end

    // PI path: integrators move by -/+ 2*error, duties by -/+ 20*error
    logic signed [SUM_W-1:0]   err_x2;
    logic signed [SUM_W-1:0]   sum_l;
    logic signed [SUM_W-1:0]   sum_r;
    logic signed [INT_W-1:0]   int_l;
    logic signed [INT_W-1:0]   int_r;
    logic signed [DUTY_XW-1:0] err_ext;
    logic signed [DUTY_XW-1:0] err_x20;
    logic signed [DUTY_XW-1:0] u_l;
    logic signed [DUTY_XW-1:0] u_r;
    logic [DUTY_W-1:0]         duty_l;
    logic [DUTY_W-1:0]         duty_r;

    assign err_x2  = {{2{i_item.error[ERR_W-1]}}, i_item.error, 1'b0};
    assign sum_l   = SUM_W'(i_state.left_int) - err_x2;
    assign sum_r   = SUM_W'(i_state.right_int) + err_x2;

    always_comb begin
        if (sum_l < INT_MIN) begin
            int_l = INT_W'(INT_MIN);
        end else if (sum_l > INT_MAX) begin
            int_l = INT_W'(INT_MAX);
        end else begin
            int_l = sum_l[INT_W-1:0];
        end
        if (sum_r < INT_MIN) begin
            int_r = INT_W'(INT_MIN);
        end else if (sum_r > INT_MAX) begin
            int_r = INT_W'(INT_MAX);
        end else begin
            int_r = sum_r[INT_W-1:0];
        end
    end

    assign err_ext = DUTY_XW'(i_item.error);
    assign err_x20 = (err_ext <<< 4) + (err_ext <<< 2);
    assign u_l     = DUTY_XW'(int_l) - err_x20;
    assign u_r     = DUTY_XW'(int_r) + err_x20;

    always_comb begin
        if (u_l < DUTY_MIN) begin
            duty_l = DUTY_W'(DUTY_MIN);
        end else if (u_l > POWER_MAX) begin
            duty_l = DUTY_W'(POWER_MAX);
        end else begin
            duty_l = u_l[DUTY_W-1:0];
        end
        if (u_r < DUTY_MIN) begin
            duty_r = DUTY_W'(DUTY_MIN);
        end else if (u_r > POWER_MAX) begin
            duty_r = DUTY_W'(POWER_MAX);
        end else begin
            duty_r = u_r[DUTY_W-1:0];
        end
    end

    // Drive path: direction, power lookup, servo lookup, inner wheel
    logic                    drv_rev;
    logic [SPD_W-1:0]        mag;
    logic [SPD_W-1:0]        mag_lim;
    logic [DUTY_W-1:0]       power;
    logic                    steer_over;
    logic signed [STR_W-1:0] steer_cl;
    logic [STR_W-1:0]        srv_off;
    logic [DUTY_W-1:0]       servo;
    logic                    inner_rev;
    logic [1:0]              inner_ch;

    // -128 negates to 8'h80, read unsigned as 128
    assign drv_rev = i_item.speed[SPD_W-1];
    assign mag     = drv_rev ? (~i_item.speed + 1'b1) : i_item.speed;
    assign mag_lim = (mag > SPD_W'(MAX_SPEED)) ? SPD_W'(MAX_SPEED) : mag;
    assign power   = pw_lut[mag_lim[PW_IW-1:0]];

    assign steer_over = (i_item.steer > STEER_LIM) || (i_item.steer < -STEER_LIM);
    always_comb begin
        if (i_item.steer > STEER_LIM) begin
            steer_cl = STR_W'(STEER_LIM);
        end else if (i_item.steer < -STEER_LIM) begin
            steer_cl = STR_W'(-STEER_LIM);
        end else begin
            steer_cl = i_item.steer;
        end
    end
    assign srv_off   = STR_W'(STEER_LIM) - steer_cl;
    assign servo     = srv_lut[srv_off[SRV_IW-1:0]];
    assign inner_rev = steer_over ? ~drv_rev : drv_rev;
    assign inner_ch  = i_item.steer[STR_W-1] ? CH_LEFT : CH_RIGHT;

    // Result list and state update per request kind
    always_comb begin
        o_state = i_state;
        o_res   = '0;
        o_cnt   = '0;
        case (t_req'(i_item.req_type))
            REQ_PI: begin
                o_state.left_int  = int_l;
                o_state.right_int = int_r;
                if (!i_state.halted) begin
                    o_res[0] = '{channel: CH_LEFT,  duty: duty_l, reverse: 1'b0, last: 1'b0};
                    o_res[1] = '{channel: CH_RIGHT, duty: duty_r, reverse: 1'b0, last: 1'b1};
                    o_cnt    = CNT_W'(2);
                end
            end
            REQ_DRIVE: begin
                if (!i_state.halted) begin
                    o_res[0] = '{channel: CH_LEFT,  duty: power, reverse: drv_rev, last: 1'b0};
                    o_res[1] = '{channel: CH_RIGHT, duty: power, reverse: drv_rev, last: 1'b0};
                    o_res[2] = '{channel: CH_SERVO, duty: servo, reverse: 1'b0,    last: 1'b0};
                    o_res[3] = '{channel: inner_ch, duty: power >> 1,
                                 reverse: inner_rev, last: 1'b1};
                    o_cnt    = CNT_W'(4);
                end
            end
            REQ_STOP: begin
                o_res[0] = '{channel: CH_LEFT,  duty: DUTY_W'(POWER_MIN),
                             reverse: 1'b0, last: 1'b0};
                o_res[1] = '{channel: CH_RIGHT, duty: DUTY_W'(POWER_MIN),
                             reverse: 1'b0, last: 1'b1};
                o_cnt          = CNT_W'(2);
                o_state.halted = 1'b1;
            end
            default: begin
                o_cnt = '0;
            end
        endcase
    end

endmodule

// ===== rtl/ddc_res_q.sv =====
module ddc_res_q import ddc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_load                 i_load,
    input  t_result [RES_MAX-1:0] i_res,
    input  logic                  i_pop,
    output logic                  o_valid,
    output logic                  o_free,
    output t_result               o_head
);

    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      n_cnt;
    t_result [RES_MAX-1:0] r_buf;
    t_result [RES_MAX-1:0] n_buf;
    logic                  pop;

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_buf[0];
    assign pop     = o_valid && i_pop;
    // Free when empty or when the final beat leaves this cycle
    assign o_free  = !o_valid || ((r_cnt == CNT_W'(1)) && i_pop);

    // Next count and contents: load replaces, pop shifts towards the head
    always_comb begin
        n_cnt = r_cnt;
        n_buf = r_buf;
        if (i_load.load) begin
            n_cnt = i_load.cnt;
            n_buf = i_res;
        end else if (pop) begin
            n_cnt = r_cnt - CNT_W'(1);
            for (int k = 0; k < RES_MAX - 1; k++) begin
                n_buf[k] = r_buf[k+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

endmodule

// ===== rtl/differential_drive_controller.sv =====
// Channel  | Dir | Handshake                  | Beat contents
// ---------+-----+----------------------------+-----------------------------------
// request  | in  | i_in_valid / o_in_ready    | i_req_type i_error i_speed i_steer
// pwm      | out | o_out_valid / i_out_ready  | o_channel o_duty o_reverse o_last
//
// A request waits in the input register until the result buffer is free,
// then is worked out and dropped into the four-entry buffer in one step;
// the first PWM beat shows the cycle after. The buffer drains one beat a
// cycle while i_out_ready is high. Drive gives 4 beats, PI and stop 2;
// drive and PI give none once halted. The next request moves in as the
// final beat leaves. Reset (synchronous, low) empties both stages and
// restores the integrators to 12100 and clears the halted flag. A stall on
// i_out_ready holds the head beat and backs up into o_in_ready.
module differential_drive_controller import ddc_pkg::*; #(
    parameter int MAX_SPEED = DEFAULT_MAX_SPEED
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_req_type,
    input  logic signed [ERR_W-1:0] i_error,
    input  logic signed [SPD_W-1:0] i_speed,
    input  logic signed [STR_W-1:0] i_steer,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [1:0]              o_channel,
    output logic [DUTY_W-1:0]       o_duty,
    output logic                    o_reverse,
    output logic                    o_last
);

    logic                  r_in_vld;
    t_item                 r_item;
    t_state                r_state;
    t_state                n_state;
    t_result [RES_MAX-1:0] calc_res;
    logic [CNT_W-1:0]      calc_cnt;
    t_load                 q_load;
    logic                  q_free;
    t_result               q_head;
    logic                  xfer;

    // Request moves into the result buffer once the buffer frees up
    assign xfer       = r_in_vld && q_free;
    assign o_in_ready = !r_in_vld || xfer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item <= '{req_type: i_req_type, error: i_error,
                        speed: i_speed, steer: i_steer};
        end
    end

    // Controller state, updated as each request is committed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{left_int: INT_W'(POWER_MAX), right_int: INT_W'(POWER_MAX),
                         halted: 1'b0};
        end else if (xfer) begin
            r_state <= n_state;
        end
    end

    ddc_calc #(
        .MAX_SPEED (MAX_SPEED)
    ) u_calc (
        .i_item  (r_item),
        .i_state (r_state),
        .o_state (n_state),
        .o_res   (calc_res),
        .o_cnt   (calc_cnt)
    );

    assign q_load = '{load: xfer, cnt: calc_cnt};

    ddc_res_q u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (q_load),
        .i_res   (calc_res),
        .i_pop   (i_out_ready),
        .o_valid (o_out_valid),
        .o_free  (q_free),
        .o_head  (q_head)
    );

    assign o_channel = q_head.channel;
    assign o_duty    = q_head.duty;
    assign o_reverse = q_head.reverse;
    assign o_last    = q_head.last;

endmodule

// ===== rtl/ddc_checker.sv =====
`include "differential_drive_controller_defines.svh"

module ddc_checker import ddc_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [1:0]        o_channel,
    input logic [DUTY_W-1:0] o_duty,
    input logic              o_reverse,
    input logic              o_last
);

    // Stalled beat holds
    `DDC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_channel) && $stable(o_duty) && $stable(o_reverse)
            && $stable(o_last),
        "pwm beat changed while stalled")

    // Servo beat is never reversed and never closes a request
    `DDC_ASSERT_NOW(a_servo_beat, i_clk, i_rst_n,
        o_out_valid && (o_channel == CH_SERVO),
        !o_reverse && !o_last,
        "bad servo beat")

    // Duty in range, channel is a real one
    `DDC_ASSERT_NOW(a_duty_range, i_clk, i_rst_n,
        o_out_valid,
        (o_duty >= INNER_MIN) && (o_duty <= POWER_MAX)
            && ((o_channel == CH_LEFT) || (o_channel == CH_RIGHT)
                || (o_channel == CH_SERVO)),
        "duty or channel out of range")

    // Remaining beats of a request follow without a gap
    `DDC_ASSERT_NEXT(a_no_gap, i_clk, i_rst_n,
        o_out_valid && i_out_ready && !o_last,
        o_out_valid,
        "gap inside a request")

endmodule

bind differential_drive_controller ddc_checker u_ddc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_channel   (o_channel),
    .o_duty      (o_duty),
    .o_reverse   (o_reverse),
    .o_last      (o_last)
);
